/* sv/slt_pkg.sv */
// slt_pkg: shared types, codes and defaults for the sorted list table
// used by slt_cell and sorted_list_table_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package slt_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_W = 32;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [1:0]                op;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] count;
   } rsp_type;

   // per-cycle command broadcast along the cell row
   typedef struct packed {
      logic compare;
      logic shift_in;
      logic shift_out;
   } cell_ctl_type;

endpackage
`default_nettype wire

/* sv/slt_cell.sv */
// slt_cell: one slot of the sorted row, holds an entry and its compare flags
// depends on slt_pkg for the value width and the command struct
`timescale 1ns / 1ps
`default_nettype none
module slt_cell (
   input  wire logic                                clock,
   input  wire slt_pkg::cell_ctl_type               ctl,
   input  wire logic signed [slt_pkg::VALUE_W-1:0]  value,
   input  wire logic                                occupied,
   input  wire logic signed [slt_pkg::VALUE_W-1:0]  left_entry,
   input  wire logic                                left_less,
   input  wire logic signed [slt_pkg::VALUE_W-1:0]  right_entry,
   output logic signed [slt_pkg::VALUE_W-1:0]       entry,
   output logic                                     less,
   output logic                                     first_eq
);

   logic signed [slt_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic less_ff, less_in;
   logic eq_ff, eq_in;

   always_comb begin
      entry_in = entry_ff;
      less_in  = less_ff;
      eq_in    = eq_ff;
      if (ctl.compare) begin
         less_in = occupied && (entry_ff < value);
         eq_in   = occupied && (entry_ff == value);
      end
      // cells below the insertion point keep their entry
      if (ctl.shift_in && !less_ff) begin
         entry_in = left_less ? value : left_entry;
      end
      if (ctl.shift_out && !less_ff) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      less_ff  <= less_in;
      eq_ff    <= eq_in;
   end

   assign entry    = entry_ff;
   assign less     = less_ff;
   // first slot that is not smaller, holding an equal value
   assign first_eq = eq_ff && !less_ff && left_less;

endmodule
`default_nettype wire

/* sv/sorted_list_table_unit.sv */
// sorted_list_table_unit: top level of the sorted insertion list
// depends on slt_pkg and a row of slt_cell instances
//
// usage:
//   requests arrive on req_valid / req_stall / req_data (op, signed value);
//   each transaction is answered by exactly one rsp_data transaction
//   (status, count) on rsp_valid / rsp_stall.
//   a request is taken only when the unit is idle; req_stall is high while the
//   cell row compares and then shifts. the result is written to the output
//   register in the shift state, after the compare state; a new request is
//   accepted only once the unit is back in idle after that shift state.
//   if rsp_stall holds the previous result, the shift cycle waits until the
//   output register frees, and the next request can be accepted while the
//   latest result still waits to be taken.
//   reset clears the count and the handshake state; the stored entries
//   are not cleared and are only read below the count.
`timescale 1ns / 1ps
`default_nettype none
module sorted_list_table_unit #(
   parameter int DEPTH = slt_pkg::DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire slt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output slt_pkg::rsp_type      rsp_data
);

   localparam int CntW = $clog2(DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_UPD  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [CntW-1:0] used_ff, used_in;
   logic rsp_valid_ff, rsp_valid_in;
   slt_pkg::rsp_type rsp_ff, rsp_in;
   slt_pkg::req_type req_ff, req_in;

   slt_pkg::cell_ctl_type ctl;
   logic signed [slt_pkg::VALUE_W-1:0] entry_w [DEPTH];
   logic less_w [DEPTH];
   logic [DEPTH-1:0] first_eq_w;
   logic hit, full, empty, upd_go;
   logic [CntW+4:0] count_ext;

   assign req_stall = (state_ff != S_IDLE);
   assign full  = (used_ff == CntW'(DEPTH));
   assign empty = (used_ff == '0);
   assign hit   = |first_eq_w;
   assign upd_go = (state_ff == S_UPD) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      ctl.compare   = (state_ff == S_CMP);
      ctl.shift_in  = upd_go && (req_ff.op == slt_pkg::OP_INSERT) && !full;
      ctl.shift_out = upd_go && (req_ff.op == slt_pkg::OP_REMOVE) && hit;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [slt_pkg::VALUE_W-1:0] left_e, right_e;
      logic left_l;
      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_l = 1'b1;
      end else begin : g_mid
         assign left_e = entry_w[i-1];
         assign left_l = less_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = entry_w[i+1];
      end
      slt_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .value       (req_ff.value),
         .occupied    (used_ff > CntW'(i)),
         .left_entry  (left_e),
         .left_less   (left_l),
         .right_entry (right_e),
         .entry       (entry_w[i]),
         .less        (less_w[i]),
         .first_eq    (first_eq_w[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      count_ext    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            if (upd_go) begin
               unique case (req_ff.op)
                  slt_pkg::OP_INSERT: begin
                     if (full) begin
                        rsp_in.status = slt_pkg::ST_FULL;
                     end else begin
                        rsp_in.status = slt_pkg::ST_DONE;
                        used_in = used_ff + 1'b1;
                     end
                  end
                  slt_pkg::OP_REMOVE: begin
                     if (empty) begin
                        rsp_in.status = slt_pkg::ST_EMPTY;
                     end else if (hit) begin
                        rsp_in.status = slt_pkg::ST_DONE;
                        used_in = used_ff - 1'b1;
                     end else begin
                        rsp_in.status = slt_pkg::ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     // search, and the unused code behaves the same
                     rsp_in.status = hit ? slt_pkg::ST_DONE : slt_pkg::ST_NOT_FOUND;
                  end
               endcase
               count_ext     = {5'b0, used_in};
               rsp_in.count  = count_ext[4:0];
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

/* bench/sorted_list_checker.sv */
// sorted_list_checker: watches both channels of sorted_list_table_unit, keeps its own
// ordered copy of the table and compares every result with the predicted one
// depends on slt_pkg for the transaction types and the op and status codes
`timescale 1ns / 1ps
module sorted_list_checker #(
   parameter int DEPTH = slt_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  slt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  slt_pkg::rsp_type rsp_data,
   output int               errors,
   output int               pending
);

   logic signed [slt_pkg::VALUE_W-1:0] shadow_list [DEPTH];
   int                                 shadow_used;
   slt_pkg::rsp_type                   awaited_answers [$];

   function automatic int first_equal(input logic signed [slt_pkg::VALUE_W-1:0] v);
      int i;
      for (i = 0; i < shadow_used; i++) begin
         if (shadow_list[i] == v) return i;
      end
      return shadow_used;
   endfunction

   // updates the shadow list and returns the answer the unit owes
   function automatic slt_pkg::rsp_type apply_request(input slt_pkg::req_type rq);
      slt_pkg::rsp_type                   ans;
      logic signed [slt_pkg::VALUE_W-1:0] v;
      int                                 pos;
      int                                 i;
      v = rq.value;
      case (rq.op)
         slt_pkg::OP_INSERT: begin
            if (shadow_used >= DEPTH) begin
               ans.status = slt_pkg::ST_FULL;
            end else begin
               pos = 0;
               while (pos < shadow_used && shadow_list[pos] < v) pos++;
               for (i = shadow_used; i > pos; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[pos] = v;
               shadow_used++;
               ans.status = slt_pkg::ST_DONE;
            end
         end
         slt_pkg::OP_REMOVE: begin
            if (shadow_used == 0) begin
               ans.status = slt_pkg::ST_EMPTY;
            end else begin
               pos = first_equal(v);
               if (pos >= shadow_used) begin
                  ans.status = slt_pkg::ST_NOT_FOUND;
               end else begin
                  for (i = pos; i + 1 < shadow_used; i++) shadow_list[i] = shadow_list[i+1];
                  shadow_used--;
                  ans.status = slt_pkg::ST_DONE;
               end
            end
         end
         // search, and the spare op code behaves the same way
         default: begin
            ans.status = (first_equal(v) < shadow_used) ? slt_pkg::ST_DONE
                                                        : slt_pkg::ST_NOT_FOUND;
         end
      endcase
      ans.count = 5'(shadow_used);
      return ans;
   endfunction

   always @(posedge clock) begin
      slt_pkg::rsp_type want;
      if (reset) begin
         errors      = 0;
         shadow_used = 0;
         awaited_answers.delete();
      end else begin
         // result side first: a result can never belong to a request taken this edge
         if (rsp_valid && !rsp_stall) begin
            if (awaited_answers.size() == 0) begin
               $display("%0t: unexpected result status=%0d count=%0d", $time,
                        rsp_data.status, rsp_data.count);
               errors++;
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status mismatch expected=%0d actual=%0d", $time,
                           want.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.count !== want.count) begin
                  $display("%0t: count mismatch expected=%0d actual=%0d", $time,
                           want.count, rsp_data.count);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) awaited_answers.push_back(apply_request(req_data));
      end
      pending = awaited_answers.size();
   end

endmodule

/* bench/tb.sv */
// tb: top of the sorted list table bench; drives directed and random requests with
// random gaps and result-side stalls, then reports the verdict
// depends on slt_pkg, sorted_list_table_unit and sorted_list_checker
`timescale 1ns / 1ps
module tb;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam logic signed [slt_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [slt_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   slt_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   slt_pkg::rsp_type rsp_data;
   int               errors;
   int               pending;

   int               stall_left;
   int               calm_left;
   logic             calm;

   sorted_list_table_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   sorted_list_checker checker_i (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .errors    (errors),
      .pending   (pending)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side back-pressure: calm stretches, short stalls and a few long ones
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         calm_left  = 0;
         calm       = 1'b1;
      end else begin
         if (calm_left == 0) begin
            calm      = ($urandom_range(0, 2) == 0);
            calm_left = $urandom_range(50, 300);
         end else begin
            calm_left--;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input logic [1:0] op,
                               input logic signed [slt_pkg::VALUE_W-1:0] v);
      req_data  <= {op, v};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic idle_gap(input logic quiet);
      int roll;
      int n;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55) n = 0;
      else if (roll < 85) n = $urandom_range(1, 3);
      else if (roll < 96) n = $urandom_range(4, 10);
      else n = $urandom_range(15, 40);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   function automatic logic signed [slt_pkg::VALUE_W-1:0] pick_value();
      logic signed [slt_pkg::VALUE_W-1:0] v;
      int                                 roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) begin
         // narrow pool so duplicates and successful removes are common
         v = $urandom_range(0, 6);
         v = v - 3;
      end else if (roll == 5) begin
         case ($urandom_range(0, 3))
            0: v = VAL_MAX;
            1: v = VAL_MIN;
            2: v = -1;
            default: v = 0;
         endcase
      end else begin
         v = $urandom;
      end
      return v;
   endfunction

   initial begin
      int          i;
      int          roll;
      int          ins_weight;
      int          rem_weight;
      logic        quiet;
      logic [1:0]  op;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table cases, one-entry remove miss, extremes, duplicates, full
      send_request(slt_pkg::OP_SEARCH, 5);   idle_gap(1'b0);
      send_request(slt_pkg::OP_REMOVE, 5);   idle_gap(1'b0);
      send_request(slt_pkg::OP_INSERT, 7);   idle_gap(1'b0);
      send_request(slt_pkg::OP_REMOVE, 3);   idle_gap(1'b0);
      send_request(OP_SPARE, 7);             idle_gap(1'b0);
      send_request(slt_pkg::OP_INSERT, VAL_MAX);
      send_request(slt_pkg::OP_INSERT, VAL_MIN);
      send_request(slt_pkg::OP_INSERT, -1);
      send_request(slt_pkg::OP_INSERT, 0);
      send_request(slt_pkg::OP_INSERT, 7);
      send_request(slt_pkg::OP_INSERT, 7);   idle_gap(1'b0);
      send_request(slt_pkg::OP_SEARCH, VAL_MIN);
      send_request(slt_pkg::OP_REMOVE, 7);
      for (i = 0; i < 10; i++) begin
         send_request(slt_pkg::OP_INSERT, pick_value());
         idle_gap(1'b0);
      end
      send_request(slt_pkg::OP_INSERT, 1);
      send_request(OP_SPARE, 12345);

      // random phases alternate between filling, draining and mixed traffic
      ins_weight = 40;
      rem_weight = 30;
      quiet      = 1'b0;
      for (i = 0; i < 825; i++) begin
         if (i % 75 == 0) begin
            case ($urandom_range(0, 2))
               0: begin ins_weight = 70; rem_weight = 15; end
               1: begin ins_weight = 20; rem_weight = 60; end
               default: begin ins_weight = 40; rem_weight = 35; end
            endcase
            quiet = ($urandom_range(0, 3) == 0);
         end
         roll = $urandom_range(0, 99);
         if (roll < ins_weight) op = slt_pkg::OP_INSERT;
         else if (roll < ins_weight + rem_weight) op = slt_pkg::OP_REMOVE;
         else if (roll < 95) op = slt_pkg::OP_SEARCH;
         else op = OP_SPARE;
         send_request(op, pick_value());
         idle_gap(quiet);
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (errors == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule
